// ===== hw/rtl/lstr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstr_pkg
// Types, codes and node arithmetic shared by the segment tree controller and
// datapath.
// ----------------------------------------------------------------------------
package lstr_pkg;

   localparam int VAL_W   = 48;
   localparam int TAG_W   = 49;
   localparam int SHIFT_W = 5;

   typedef logic [VAL_W-1:0] val_type;
   typedef logic [TAG_W-1:0] tag_type;

   localparam val_type MIN_IDENT = 48'h0000_7FFF_FFFF;

   localparam logic [1:0] CMD_SET    = 2'd0;
   localparam logic [1:0] CMD_UPDATE = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   localparam logic [1:0] MODE_MIN_ASSIGN = 2'd0;
   localparam logic [1:0] MODE_MIN_ADD    = 2'd1;
   localparam logic [1:0] MODE_SUM_ADD    = 2'd2;
   localparam logic [1:0] MODE_SUM_ASSIGN = 2'd3;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE,
      ST_PD_RD, ST_PD_CHK, ST_PD_C0, ST_PD_C1, ST_PD_WP, ST_PD_NEXT,
      ST_LEAF,
      ST_LOOP, ST_L_WAIT, ST_RCHK, ST_R_WAIT, ST_SHIFT,
      ST_PL_RD, ST_PL_C0, ST_PL_WR,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      WS_CLEAR, WS_TAG_PUSH, WS_TAG_UPDATE, WS_PUSH_PARENT, WS_LEAF, WS_PULL
   } wsrc_type;

   typedef struct packed {
      logic                 start;
      logic                 val_we;
      logic                 tag_we;
      wsrc_type             wsrc;
      logic                 latch_p;
      logic                 acc_l_en;
      logic                 acc_r_en;
      logic                 out_load;
      logic [SHIFT_W-1:0]   shift;
   } ctl_type;

   typedef struct packed {
      logic has_tag;
      logic out_free;
   } status_type;

   function automatic logic is_min(input logic [1:0] mode);
      return (mode == MODE_MIN_ASSIGN) || (mode == MODE_MIN_ADD);
   endfunction

   function automatic logic is_assign(input logic [1:0] mode);
      return (mode == MODE_MIN_ASSIGN) || (mode == MODE_SUM_ASSIGN);
   endfunction

   function automatic val_type identity(input logic [1:0] mode);
      return is_min(mode) ? MIN_IDENT : '0;
   endfunction

   function automatic val_type combine(input logic [1:0] mode, input val_type a,
                                       input val_type b);
      if (is_min(mode)) begin
         return ($signed(a) <= $signed(b)) ? a : b;
      end
      return a + b;
   endfunction

   function automatic logic has_tag(input logic [1:0] mode, input tag_type t);
      return is_assign(mode) ? t[TAG_W-1] : (|t[VAL_W-1:0]);
   endfunction

   function automatic tag_type compose(input logic [1:0] mode, input tag_type old_t,
                                       input tag_type new_t);
      if (is_assign(mode)) begin
         return new_t[TAG_W-1] ? new_t : old_t;
      end
      return {1'b0, old_t[VAL_W-1:0] + new_t[VAL_W-1:0]};
   endfunction

   // value of a node with its pending tag applied, segment size 2^shift
   function automatic val_type node_eval(input logic [1:0] mode, input val_type v,
                                         input tag_type t, input logic [SHIFT_W-1:0] shift);
      val_type a;
      a = t[VAL_W-1:0];
      case (mode)
         MODE_MIN_ASSIGN: return t[TAG_W-1] ? a : v;
         MODE_MIN_ADD:    return v + a;
         MODE_SUM_ADD:    return v + (a << shift);
         default:         return t[TAG_W-1] ? (a << shift) : v;
      endcase
   endfunction

endpackage

// ===== hw/rtl/lstr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstr_ctrl
// Sequencer: clearing sweep, tag push-down along one root path or two, range
// walk and parent recompute, issuing memory addresses and datapath commands.
// ----------------------------------------------------------------------------
module lstr_ctrl #(
   parameter int TREE_HEIGHT = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [1:0]                            command,
   input  logic [10:0]                           index_low,
   input  logic [10:0]                           index_high,
   input  logic                                  csr_wen,
   input  lstr_pkg::status_type                  status,
   output lstr_pkg::ctl_type                     ctl,
   output logic [TREE_HEIGHT:0]                  rd_addr,
   output logic [TREE_HEIGHT:0]                  wr_addr
);
   import lstr_pkg::*;

   localparam int LEAVES = 1 << TREE_HEIGHT;
   localparam int NW     = TREE_HEIGHT + 1;
   localparam int LW     = TREE_HEIGHT + 2;
   localparam int SW     = $clog2(TREE_HEIGHT + 3);

   state_type     state_ff, state_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic [NW-1:0] a_ff, a_in, b_ff, b_in, clr_ff, clr_in;
   logic [LW-1:0] l_ff, l_in, r_ff, r_in, r_m1;
   logic [SW-1:0] step_ff, step_in;
   logic          path_ff, path_in;

   logic [31:0]   lo32, hi32;
   logic          valid_set, valid_rng;
   logic [NW-1:0] leaf_lo, leaf_hi, base, node, child0, child1;
   logic          step_last, step_top;

   assign lo32      = {21'b0, index_low};
   assign hi32      = {21'b0, index_high};
   assign valid_set = lo32 < 32'(LEAVES);
   assign valid_rng = (lo32 < hi32) && (hi32 <= 32'(LEAVES));
   assign leaf_lo   = lo32[NW-1:0] + NW'(LEAVES);
   assign leaf_hi   = hi32[NW-1:0] + NW'(LEAVES - 1);
   assign base      = path_ff ? b_ff : a_ff;
   assign node      = base >> step_ff;
   assign child0    = {node[NW-2:0], 1'b0};
   assign child1    = {node[NW-2:0], 1'b1};
   assign step_last = (step_ff == SW'(1));
   assign step_top  = (step_ff == SW'(TREE_HEIGHT));
   assign r_m1      = r_ff - LW'(1);

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      l_in     = l_ff;
      r_in     = r_ff;
      step_in  = step_ff;
      path_in  = path_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + NW'(1);
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in  = command;
               a_in    = leaf_lo;
               b_in    = leaf_hi;
               l_in    = {1'b0, leaf_lo};
               r_in    = {1'b0, leaf_hi} + LW'(1);
               step_in = SW'(TREE_HEIGHT);
               path_in = 1'b0;
               case (command)
                  CMD_SET:    if (valid_set) state_in = ST_PD_RD;
                  CMD_UPDATE: if (valid_rng) state_in = ST_PD_RD;
                  CMD_QUERY:  state_in = valid_rng ? ST_PD_RD : ST_OUT;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_PD_RD:  state_in = ST_PD_CHK;
         ST_PD_CHK: state_in = status.has_tag ? ST_PD_C0 : ST_PD_NEXT;
         ST_PD_C0:  state_in = ST_PD_C1;
         ST_PD_C1:  state_in = ST_PD_WP;
         ST_PD_WP:  state_in = ST_PD_NEXT;
         ST_PD_NEXT: begin
            if (!step_last) begin
               step_in  = step_ff - SW'(1);
               state_in = ST_PD_RD;
            end else if (cmd_ff == CMD_SET) begin
               state_in = ST_LEAF;
            end else if (!path_ff) begin
               path_in  = 1'b1;
               step_in  = SW'(TREE_HEIGHT);
               state_in = ST_PD_RD;
            end else begin
               step_in  = '0;
               state_in = ST_LOOP;
            end
         end
         ST_LEAF: begin
            path_in  = 1'b0;
            step_in  = SW'(1);
            state_in = ST_PL_RD;
         end
         ST_LOOP: begin
            if (l_ff < r_ff) begin
               state_in = l_ff[0] ? ST_L_WAIT : ST_RCHK;
            end else if (cmd_ff == CMD_UPDATE) begin
               path_in  = 1'b0;
               step_in  = SW'(1);
               state_in = ST_PL_RD;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_L_WAIT: begin
            l_in     = l_ff + LW'(1);
            state_in = ST_RCHK;
         end
         ST_RCHK: begin
            if (r_ff[0]) begin
               r_in     = r_m1;
               state_in = ST_R_WAIT;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_R_WAIT: state_in = ST_SHIFT;
         ST_SHIFT: begin
            l_in     = l_ff >> 1;
            r_in     = r_ff >> 1;
            step_in  = step_ff + SW'(1);
            state_in = ST_LOOP;
         end
         ST_PL_RD: state_in = ST_PL_C0;
         ST_PL_C0: state_in = ST_PL_WR;
         ST_PL_WR: begin
            if (!step_top) begin
               step_in  = step_ff + SW'(1);
               state_in = ST_PL_RD;
            end else if ((cmd_ff == CMD_UPDATE) && !path_ff) begin
               path_in  = 1'b1;
               step_in  = SW'(1);
               state_in = ST_PL_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: if (status.out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      // a mode write restarts the clearing sweep
      if (csr_wen) begin
         state_in = ST_CLEAR;
         clr_in   = '0;
      end
   end

   always_comb begin
      ctl        = '0;
      ctl.wsrc   = WS_CLEAR;
      ctl.shift  = SHIFT_W'(step_ff);
      req_tready = 1'b0;
      rd_addr    = node;
      wr_addr    = node;
      case (state_ff)
         ST_CLEAR: begin
            wr_addr    = clr_ff;
            ctl.val_we = 1'b1;
            ctl.tag_we = 1'b1;
            ctl.wsrc   = WS_CLEAR;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            ctl.start  = req_tvalid;
         end
         ST_PD_CHK: begin
            rd_addr     = child0;
            ctl.latch_p = 1'b1;
         end
         ST_PD_C0: begin
            wr_addr    = child0;
            rd_addr    = child1;
            ctl.tag_we = 1'b1;
            ctl.wsrc   = WS_TAG_PUSH;
         end
         ST_PD_C1: begin
            wr_addr    = child1;
            ctl.tag_we = 1'b1;
            ctl.wsrc   = WS_TAG_PUSH;
         end
         ST_PD_WP: begin
            ctl.val_we = 1'b1;
            ctl.tag_we = 1'b1;
            ctl.wsrc   = WS_PUSH_PARENT;
         end
         ST_LEAF: begin
            wr_addr    = a_ff;
            ctl.val_we = 1'b1;
            ctl.tag_we = 1'b1;
            ctl.wsrc   = WS_LEAF;
         end
         ST_LOOP: rd_addr = l_ff[NW-1:0];
         ST_L_WAIT: begin
            wr_addr = l_ff[NW-1:0];
            if (cmd_ff == CMD_UPDATE) begin
               ctl.tag_we = 1'b1;
               ctl.wsrc   = WS_TAG_UPDATE;
            end else begin
               ctl.acc_l_en = 1'b1;
            end
         end
         ST_RCHK: rd_addr = r_m1[NW-1:0];
         ST_R_WAIT: begin
            wr_addr = r_ff[NW-1:0];
            if (cmd_ff == CMD_UPDATE) begin
               ctl.tag_we = 1'b1;
               ctl.wsrc   = WS_TAG_UPDATE;
            end else begin
               ctl.acc_r_en = 1'b1;
            end
         end
         ST_PL_RD: rd_addr = child0;
         ST_PL_C0: begin
            rd_addr     = child1;
            ctl.latch_p = 1'b1;
         end
         ST_PL_WR: begin
            ctl.val_we = 1'b1;
            ctl.wsrc   = WS_PULL;
            ctl.shift  = SHIFT_W'(step_ff - SW'(1));
         end
         ST_OUT: ctl.out_load = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         cmd_ff   <= CMD_SET;
         step_ff  <= '0;
         path_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         cmd_ff   <= cmd_in;
         step_ff  <= step_in;
         path_ff  <= path_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      l_ff <= l_in;
      r_ff <= r_in;
   end

   a_mode_clears: assert property (@(posedge clock) disable iff (reset)
      csr_wen |=> (state_ff == ST_CLEAR))
      else $error("mode write did not start the clearing sweep");

   a_left_odd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_L_WAIT) |-> l_ff[0])
      else $error("left boundary node taken while even");

   a_push_ports_apart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PD_C0) |-> (wr_addr != rd_addr))
      else $error("push-down writes and reads the same child");

   a_push_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PD_RD) |-> (step_ff != '0))
      else $error("push-down reached the leaf level");

endmodule

// ===== hw/rtl/lstr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstr_datapath
// Node value and tag memories, mode register, operand, range accumulators
// and the result register.
// ----------------------------------------------------------------------------
module lstr_datapath #(
   parameter int TREE_HEIGHT = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [1:0]             csr_wdata,
   input  logic signed [31:0]     operand_value,
   input  lstr_pkg::ctl_type      ctl,
   input  logic [TREE_HEIGHT:0]   rd_addr,
   input  logic [TREE_HEIGHT:0]   wr_addr,
   output lstr_pkg::status_type   status,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [47:0]            rsp_tdata
);
   import lstr_pkg::*;

   localparam int DEPTH = 2 << TREE_HEIGHT;

   val_type val_mem [DEPTH];
   tag_type tag_mem [DEPTH];

   logic [1:0] mode_ff;
   val_type    rd_val_ff, p_val_ff, x_ff, acc_l_ff, acc_r_ff, out_ff;
   tag_type    rd_tag_ff, p_tag_ff;
   logic       out_valid_ff;

   val_type    ev_rd, ev_p, wr_val;
   tag_type    upd_tag, wr_tag;

   assign ev_rd   = node_eval(mode_ff, rd_val_ff, rd_tag_ff, ctl.shift);
   assign ev_p    = node_eval(mode_ff, p_val_ff, p_tag_ff, ctl.shift);
   assign upd_tag = {is_assign(mode_ff), x_ff};

   always_comb begin
      wr_val = ev_p;
      wr_tag = '0;
      case (ctl.wsrc)
         WS_CLEAR:       wr_val = identity(mode_ff);
         WS_TAG_PUSH:    wr_tag = compose(mode_ff, rd_tag_ff, p_tag_ff);
         WS_TAG_UPDATE:  wr_tag = compose(mode_ff, rd_tag_ff, upd_tag);
         WS_PUSH_PARENT: wr_val = ev_p;
         WS_LEAF:        wr_val = x_ff;
         WS_PULL:        wr_val = combine(mode_ff, ev_p, ev_rd);
         default:        wr_val = ev_p;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.val_we) val_mem[wr_addr] <= wr_val;
      if (ctl.tag_we) tag_mem[wr_addr] <= wr_tag;
      rd_val_ff <= val_mem[rd_addr];
      rd_tag_ff <= tag_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_MIN_ADD;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) mode_ff <= csr_wdata;
         if (ctl.out_load) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
      if (ctl.start) begin
         x_ff     <= VAL_W'(operand_value);
         acc_l_ff <= identity(mode_ff);
         acc_r_ff <= identity(mode_ff);
      end else begin
         if (ctl.acc_l_en) acc_l_ff <= combine(mode_ff, acc_l_ff, ev_rd);
         if (ctl.acc_r_en) acc_r_ff <= combine(mode_ff, ev_rd, acc_r_ff);
      end
      if (ctl.latch_p) begin
         p_val_ff <= rd_val_ff;
         p_tag_ff <= rd_tag_ff;
      end
      if (ctl.out_load) out_ff <= combine(mode_ff, acc_l_ff, acc_r_ff);
   end

   assign status.has_tag  = has_tag(mode_ff, rd_tag_ff);
   assign status.out_free = !out_valid_ff || rsp_tready;
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_tdata       = out_ff;

endmodule

// ===== hw/rtl/lazy_segment_tree_range_ops.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lazy_segment_tree_range_ops
// Lazy segment tree over 2^TREE_HEIGHT signed 48-bit elements with point
// set, range add/assign and range min/sum query.
// ----------------------------------------------------------------------------
// Usage:
//  req channel carries one command item: set one element, range update or
//  range query. Only a query returns an item on the rsp channel.
//  csr_wen writes the 2-bit mode (min/assign, min/add, sum/add, sum/assign)
//  and clears the whole tree to the mode's identity.
//  Flow: one item at a time. A command pushes pending tags down along the
//  root path of its low leaf and, but for a set, of its high leaf; an update
//  or query then walks the range boundary, and a set or update recomputes
//  the parents along its paths. An unused code, a bad set or an empty update
//  is taken and dropped in idle; an empty query returns the mode's identity.
//  Reset and every mode write run a clearing sweep over all 2^(TREE_HEIGHT+1)
//  node entries (2048 at the default), during which req_tready stays low.
//  A query result waits in an output register; the next item is taken
//  meanwhile, and a further query holds at its end until rsp_tready.
// ----------------------------------------------------------------------------
module lazy_segment_tree_range_ops #(
   parameter int TREE_HEIGHT = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command[1:0], index_low[12:2], index_high[23:13], operand_value[55:24]
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // query_result[47:0]
   output logic [47:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [1:0]  csr_wdata
);
   import lstr_pkg::*;

   ctl_type                    ctl;
   status_type                 status;
   logic [TREE_HEIGHT:0]       rd_addr, wr_addr;
   logic signed [31:0]         operand_value;

   assign operand_value = $signed(req_tdata[55:24]);

   lstr_ctrl #(.TREE_HEIGHT(TREE_HEIGHT)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .command    (req_tdata[1:0]),
      .index_low  (req_tdata[12:2]),
      .index_high (req_tdata[23:13]),
      .csr_wen    (csr_wen),
      .status     (status),
      .ctl        (ctl),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr)
   );

   lstr_datapath #(.TREE_HEIGHT(TREE_HEIGHT)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .operand_value (operand_value),
      .ctl           (ctl),
      .rd_addr       (rd_addr),
      .wr_addr       (wr_addr),
      .status        (status),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

endmodule
